[design/bclru_pkg.sv]
// Shared constants, outcome codes and controller/datapath interface types.
package bclru_pkg;

  localparam int SLOTS_DEF         = 64;
  localparam int BLOCK_BYTES_DEF   = 512;
  localparam int POSITION_BITS_DEF = 48;
  localparam int AGE_BITS_DEF      = 16;

  localparam int POS_W     = 48;
  localparam int SLOT_W    = 6;
  localparam int OUTCOME_W = 3;
  localparam int S_DATA_W  = 56;
  localparam int M_DATA_W  = 56;

  localparam logic OP_GET     = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT      = 3'd0,
    OUT_FILL     = 3'd1,
    OUT_EVICT    = 3'd2,
    OUT_MISALIGN = 3'd3,
    OUT_RELEASE  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic load;    // capture request beat, restart scan
    logic issue;   // read slot at scan counter
    logic commit;  // decide, update directory, load result register
  } cmd_t;

  typedef struct packed {
    logic req_rel;    // request is a release
    logic rel_oob;    // release names a slot beyond the directory
    logic scan_last;  // scan counter sits on the last slot
    logic rem_busy;   // alignment check still running
  } status_t;

endpackage

[design/bclru_ctrl.sv]
// Sequencer: accept, slot scan, drain, commit; owns the result valid flag.
module bclru_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output bclru_pkg::cmd_t   cmd,
  input  bclru_pkg::status_t status
);

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, FIN} state_t;

  state_t state;
  logic   go;

  assign s_tready = (state == IDLE);
  assign go = (!m_tvalid || m_tready) && (status.req_rel || !status.rem_busy);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE:    cmd.load   = s_tvalid;
      SCAN:    cmd.issue  = !status.rel_oob;
      DRAIN:   ;
      FIN:     cmd.commit = go;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) state <= SCAN;
        end
        SCAN: begin
          if (status.rel_oob) state <= FIN;
          else if (status.scan_last) state <= DRAIN;
        end
        DRAIN: state <= FIN;
        FIN: begin
          if (go) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[design/bclru_dpath.sv]
// Directory datapath: tag and age memories, scan pipeline, alignment check, result register.
module bclru_dpath #(
  parameter int SLOTS         = bclru_pkg::SLOTS_DEF,
  parameter int BLOCK_BYTES   = bclru_pkg::BLOCK_BYTES_DEF,
  parameter int POSITION_BITS = bclru_pkg::POSITION_BITS_DEF,
  parameter int AGE_BITS      = bclru_pkg::AGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [bclru_pkg::S_DATA_W-1:0]  in_data,
  input  logic                            in_user,
  input  bclru_pkg::cmd_t                 cmd,
  output bclru_pkg::status_t              status,
  output logic [bclru_pkg::M_DATA_W-1:0]  out_data,
  output logic [bclru_pkg::OUTCOME_W-1:0] out_user
);

  localparam int P = bclru_pkg::POS_W;
  localparam int S = bclru_pkg::SLOT_W;

  // count of trailing zero bits of a constant
  function automatic int low_zeros(input int b);
    int v;
    int n;
    v = b;
    n = 0;
    while ((v > 1) && (v[0] == 1'b0)) begin
      v = v >>> 1;
      n = n + 1;
    end
    return n;
  endfunction

  // inverse of an odd constant modulo 2^64, Newton iteration
  function automatic logic [63:0] odd_inverse(input logic [63:0] d);
    logic [63:0] x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = x * (64'd2 - d * x);
    end
    return x;
  endfunction

  localparam int CW    = $clog2(SLOTS);
  localparam int TAG_W = (POSITION_BITS < bclru_pkg::POS_W) ? POSITION_BITS : bclru_pkg::POS_W;
  localparam int BZ    = low_zeros(BLOCK_BYTES);
  localparam int ODD   = BLOCK_BYTES >> BZ;
  localparam logic [63:0] LOW_MASK_X = (64'd1 << BZ) - 64'd1;
  localparam logic [63:0] INV_X      = odd_inverse(64'(ODD));
  localparam logic [63:0] LIM_X      = 64'hFFFF_FFFF_FFFF / 64'(ODD);
  localparam logic [P-1:0] LOW_MASK  = LOW_MASK_X[P-1:0];
  localparam logic [P-1:0] INV       = INV_X[P-1:0];
  localparam logic [P-1:0] LIM       = LIM_X[P-1:0];
  localparam int RCW = 2;
  localparam logic [CW-1:0]     LAST      = CW'(SLOTS - 1);
  localparam logic [RCW-1:0]    REM_STEPS = 2'd3;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // request
  logic              req_rel;
  logic [TAG_W-1:0]  req_pos;
  logic [S-1:0]      req_idx;
  logic              req_dirty;
  logic [CW-1:0]     idx_c;

  // directory
  logic [TAG_W-1:0]    tag_mem [SLOTS];
  logic [AGE_BITS-1:0] age_mem [SLOTS];
  logic [SLOTS-1:0]    slot_valid;
  logic                age_init;   // set once a release sweep has written every age

  // scan pipeline
  logic [CW-1:0]       cnt;
  logic                pipe_vld;
  logic [CW-1:0]       pipe_idx;
  logic [TAG_W-1:0]    tag_rd;
  logic [AGE_BITS-1:0] age_rd;
  logic [AGE_BITS-1:0] age_eff;
  logic [AGE_BITS-1:0] age_new;
  logic                age_we;

  // scan results
  logic                hit_found;
  logic [CW-1:0]       hit_idx;
  logic                empty_found;
  logic [CW-1:0]       empty_idx;
  logic [AGE_BITS-1:0] best_age;
  logic [CW-1:0]       lru_idx;
  logic [TAG_W-1:0]    rel_tag;
  logic                pipe_valid_bit;
  logic                pipe_is_idx;

  // alignment: low bits by mask; odd factor by multiplying with its inverse
  // mod 2^48, a multiple maps at or below LIM; three 16-bit chunks, top first
  logic [P-1:0]     pos_in;
  logic [P-1:0]     rem_y;
  logic [P-1:0]     rem_acc;
  logic [P-1:0]     rem_chunk;
  logic [RCW-1:0]   rem_cnt;
  logic             low_bad;
  logic             misaligned;

  // commit
  logic              rel_oob;
  logic              get_write;
  logic [CW-1:0]     tag_wa;
  logic              rel_store;

  assign idx_c      = CW'(req_idx);
  assign rel_oob    = req_rel && (32'(req_idx) >= 32'(SLOTS));
  assign misaligned = low_bad || (rem_acc > LIM);

  assign status.req_rel   = req_rel;
  assign status.rel_oob   = rel_oob;
  assign status.scan_last = (cnt == LAST);
  assign status.rem_busy  = (rem_cnt != '0);

  assign age_eff        = age_init ? age_rd : '0;
  assign pipe_valid_bit = slot_valid[pipe_idx];
  assign pipe_is_idx    = (pipe_idx == idx_c);
  assign age_we         = pipe_vld && req_rel;
  assign age_new        = pipe_is_idx ? '0 :
                          ((age_eff == AGE_MAX) ? AGE_MAX : age_eff + AGE_BITS'(1));
  assign pos_in         = P'(in_data[TAG_W-1:0]);
  assign rem_chunk      = {{(P-16){1'b0}}, rem_y[P-1:P-16]};

  assign get_write = cmd.commit && !req_rel && !misaligned && !hit_found;
  assign tag_wa    = empty_found ? empty_idx : lru_idx;
  assign rel_store = !rel_oob && req_dirty && slot_valid[idx_c];

  // request capture and scan counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_rel   <= in_user;
      req_pos   <= in_data[TAG_W-1:0];
      req_idx   <= in_data[P+S-1:P];
      req_dirty <= in_data[P+S];
      cnt       <= '0;
    end else if (cmd.issue && (cnt != LAST)) begin
      cnt <= cnt + CW'(1);
    end
  end

  // memories: registered reads at the scan counter, writes from pipeline or commit
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      tag_rd   <= tag_mem[cnt];
      age_rd   <= age_mem[cnt];
      pipe_idx <= cnt;
    end
    if (age_we) age_mem[pipe_idx] <= age_new;
    if (get_write) tag_mem[tag_wa] <= req_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld   <= 1'b0;
      slot_valid <= '0;
      age_init   <= 1'b0;
    end else begin
      pipe_vld <= cmd.issue;
      if (age_we && (pipe_idx == LAST)) age_init <= 1'b1;
      if (get_write) slot_valid[tag_wa] <= 1'b1;
    end
  end

  // scan evaluation: first hit, first empty, oldest (lowest index on ties)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else if (pipe_vld) begin
      if (pipe_valid_bit && (tag_rd == req_pos) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= pipe_idx;
      end
      if (!pipe_valid_bit && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= pipe_idx;
      end
      if ((pipe_idx == '0) || (age_eff > best_age)) begin
        best_age <= age_eff;
        lru_idx  <= pipe_idx;
      end
      if (pipe_is_idx) rel_tag <= tag_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_cnt <= '0;
    end else if (cmd.load) begin
      rem_cnt <= REM_STEPS;
    end else if (rem_cnt != '0) begin
      rem_cnt <= rem_cnt - RCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_y   <= pos_in >> BZ;
      rem_acc <= '0;
      low_bad <= ((pos_in & LOW_MASK) != '0);
    end else if (rem_cnt != '0) begin
      rem_y   <= {rem_y[P-17:0], 16'b0};
      rem_acc <= {rem_acc[P-17:0], 16'b0} + (rem_chunk * INV);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (req_rel) begin
        out_user <= bclru_pkg::OUT_RELEASE;
        out_data <= {(rel_store ? P'(rel_tag) : {P{1'b0}}), rel_store, 1'b0, req_idx};
      end else if (misaligned) begin
        out_user <= bclru_pkg::OUT_MISALIGN;
        out_data <= '0;
      end else if (hit_found) begin
        out_user <= bclru_pkg::OUT_HIT;
        out_data <= {P'(req_pos), 1'b0, 1'b0, S'(hit_idx)};
      end else if (empty_found) begin
        out_user <= bclru_pkg::OUT_FILL;
        out_data <= {P'(req_pos), 1'b0, 1'b1, S'(empty_idx)};
      end else begin
        out_user <= bclru_pkg::OUT_EVICT;
        out_data <= {P'(req_pos), 1'b0, 1'b1, S'(lru_idx)};
      end
    end
  end

endmodule

[design/block_cache_lru_directory_top.sv]
// Fully associative block cache directory with LRU-by-age replacement.
// Steps: accept the beat, scan every slot of the tag/age memory, drain, commit the result; a get's
//   alignment check finishes inside the scan.
// One item at a time: a new beat is accepted only after the last one's result is committed;
//   a release of a slot beyond the directory skips the scan and goes straight to commit.
// Reset: synchronous; clears slot valid bits and the age-written flag (ages read as zero).
module block_cache_lru_directory_top #(
  parameter int SLOTS         = bclru_pkg::SLOTS_DEF,
  parameter int BLOCK_BYTES   = bclru_pkg::BLOCK_BYTES_DEF,
  parameter int POSITION_BITS = bclru_pkg::POSITION_BITS_DEF,
  parameter int AGE_BITS      = bclru_pkg::AGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // block_position[47:0], slot_index[53:48], dirty[54], zero[55]
  input  logic [bclru_pkg::S_DATA_W-1:0]  s_tdata,
  // operation[0]
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // slot[5:0], fetch_request[6], store_request[7], position[55:8]
  output logic [bclru_pkg::M_DATA_W-1:0]  m_tdata,
  // outcome[2:0]
  output logic [bclru_pkg::OUTCOME_W-1:0] m_tuser
);

  bclru_pkg::cmd_t    cmd;
  bclru_pkg::status_t status;

  bclru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  bclru_dpath #(
    .SLOTS         (SLOTS),
    .BLOCK_BYTES   (BLOCK_BYTES),
    .POSITION_BITS (POSITION_BITS),
    .AGE_BITS      (AGE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .in_user  (s_tuser[0]),
    .cmd      (cmd),
    .status   (status),
    .out_data (m_tdata),
    .out_user (m_tuser)
  );

  // result register is never overwritten while a beat waits
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("commit while result beat pending");

  // one item in flight: no new beat right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted during scan");

  // fetch only on fill or eviction
  a_fetch_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[6]) |->
      (m_tuser == bclru_pkg::OUT_FILL || m_tuser == bclru_pkg::OUT_EVICT))
    else $error("fetch on wrong outcome");

  // out-of-range release never touches the memories
  a_oob_noscan: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !status.rel_oob)
    else $error("scan issued for out-of-range release");

endmodule
